// ===== design/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter pipeline.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps

package rhc_pkg;

  // Field and datapath widths
  localparam int CH_W    = 8;
  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int DIFF_W  = CH_W + 1;
  localparam int QUO_W   = 9;
  localparam int DIV_W   = CH_W + 1;
  localparam int DSH_W   = DIV_W + QUO_W - 1;
  localparam int REM_W   = 18;
  localparam int TSUM_W  = 12;
  localparam int TPOS_W  = 11;
  localparam int PROD_W  = 32;

  // Quotient bits resolved by each divider stage
  localparam int DIV_BITS_PER_STAGE = 3;

  // Brightness: floor((200*max + 255) / 510) by reciprocal multiply,
  // folded into max * BRI_MUL + BRI_ADD, then shifted down by BRI_SHIFT.
  localparam logic [PROD_W-1:0] BRI_MUL   = 32'd13158800;
  localparam logic [PROD_W-1:0] BRI_ADD   = 32'd16777470;
  localparam int                BRI_SHIFT = 25;

  // Hue scale: 2 * 60 for the half-up rounding numerator
  localparam logic [REM_W-1:0] HUE_SCALE = 18'd120;
  // Saturation scale: 2 * 100
  localparam logic [REM_W-1:0] SAT_SCALE = 18'd200;

  // Channel that holds the maximum
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  // Request payload
  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_t;

  // Result payload
  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0] saturation_pct;
    logic [PCT_W-1:0] brightness_pct;
  } hsv_t;

  // Classification passed from stage one to stage two
  typedef struct packed {
    logic [CH_W-1:0]          mx;
    logic [CH_W-1:0]          delta;
    max_sel_t                 sel;
    logic signed [DIFF_W-1:0] diff;
  } class_t;

  // One lane of the restoring divider
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Everything a divider stage carries
  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [PCT_W-1:0] bri;
  } div_stg_t;

endpackage

// ===== design/rgb_to_hsv_converter_top.sv =====
// Top level of the RGB to HSV converter: classify, numerator and divider stages.
// Depends on rhc_pkg, rhc_classify, rhc_numer and rhc_div_stage.
//
//   channel   ports                    direction  handshake
//   request   start, busy, in_pixel    in         taken when start && !busy
//   result    out_valid, out_hsv       out        one-cycle strobe, no backpressure
//
// An accepted request reaches its out_valid strobe through one classify stage,
// one numerator stage and three divider stages of 3 quotient bits.
// Throughput is one pixel per clock; busy is held low at all times.
// Synchronous active-low reset clears the valid bits of every stage only.
// The receiver cannot stall, so no stage ever holds; results leave in request order.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  pixel_t in_pixel,
  output logic   out_valid,
  output hsv_t   out_hsv
);

  localparam int NUM_DIV_STAGES = (QUO_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

  logic     cls_vld;
  class_t   cls;
  logic     div_vld [NUM_DIV_STAGES+1];
  div_stg_t div_stg [NUM_DIV_STAGES+1];

  // Never refuse a request
  assign busy = 1'b0;

  rhc_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (start),
    .pix_i (in_pixel),
    .vld_o (cls_vld),
    .cls_o (cls)
  );

  rhc_numer u_numer (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (cls_vld),
    .cls_i (cls),
    .vld_o (div_vld[0]),
    .stg_o (div_stg[0])
  );

  // Chain the divider stages
  for (genvar s = 0; s < NUM_DIV_STAGES; s++) begin : g_div
    rhc_div_stage u_div_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (div_vld[s]),
      .stg_i (div_stg[s]),
      .vld_o (div_vld[s+1]),
      .stg_o (div_stg[s+1])
    );
  end

  // Drive results straight from the last divider register
  assign out_valid              = div_vld[NUM_DIV_STAGES];
  assign out_hsv.hue_deg        = div_stg[NUM_DIV_STAGES].hue.quo[HUE_W-1:0];
  assign out_hsv.saturation_pct = div_stg[NUM_DIV_STAGES].sat.quo[PCT_W-1:0];
  assign out_hsv.brightness_pct = div_stg[NUM_DIV_STAGES].bri;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
     $past(rst_n, 4) && $past(rst_n, 5)) |-> (out_valid == $past(start, 5)))
    else $error("result strobe does not follow request by pipeline latency");

  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hsv.hue_deg <= HUE_W'(360)))
    else $error("hue above a full turn");

  a_sat_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hsv.saturation_pct <= PCT_W'(100)))
    else $error("saturation above 100 percent");

  a_bri_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hsv.brightness_pct <= PCT_W'(100)))
    else $error("brightness above 100 percent");

  a_quo_fits : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (div_stg[NUM_DIV_STAGES].sat.quo[QUO_W-1:PCT_W] == '0))
    else $error("saturation quotient overflows its field");
`endif

endmodule

// ===== design/rhc_classify.sv =====
// Stage one: finds max, min, delta, the dominant channel and its difference term.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_classify import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_i,
  input  pixel_t pix_i,
  output logic   vld_o,
  output class_t cls_o
);

  logic              vld_r;
  class_t            cls_r;
  class_t            cls_nxt;
  logic [CH_W-1:0]   r_v, g_v, b_v;
  logic [CH_W-1:0]   mx_v, mn_v;

  // Pick max and min, red wins ties over green, green over blue
  always_comb begin
    r_v = pix_i.red_in;
    g_v = pix_i.green_in;
    b_v = pix_i.blue_in;
    mx_v = (r_v > g_v) ? r_v : g_v;
    mx_v = (mx_v > b_v) ? mx_v : b_v;
    mn_v = (r_v < g_v) ? r_v : g_v;
    mn_v = (mn_v < b_v) ? mn_v : b_v;

    cls_nxt.mx    = mx_v;
    cls_nxt.delta = mx_v - mn_v;
    priority if (r_v == mx_v) begin
      cls_nxt.sel  = SEL_RED;
      cls_nxt.diff = $signed({1'b0, g_v}) - $signed({1'b0, b_v});
    end else if (g_v == mx_v) begin
      cls_nxt.sel  = SEL_GREEN;
      cls_nxt.diff = $signed({1'b0, b_v}) - $signed({1'b0, r_v});
    end else begin
      cls_nxt.sel  = SEL_BLUE;
      cls_nxt.diff = $signed({1'b0, r_v}) - $signed({1'b0, g_v});
    end
  end

  // Advance valid under reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  assign vld_o = vld_r;
  assign cls_o = cls_r;

endmodule

// ===== design/rhc_numer.sv =====
// Stage two: forms dividends and divisors for hue and saturation, and brightness.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_numer import rhc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     vld_i,
  input  class_t   cls_i,
  output logic     vld_o,
  output div_stg_t stg_o
);

  logic                     vld_r;
  div_stg_t                 stg_r;
  div_stg_t                 stg_nxt;
  logic [CH_W+1:0]          off_v;
  logic signed [TSUM_W-1:0] tsum_v;
  logic [TPOS_W-1:0]        tpos_v;
  logic [DIV_W-1:0]         hue_div_v;
  logic [DIV_W-1:0]         sat_div_v;
  logic [PROD_W-1:0]        bri_prod_v;

  // Offset in sextants times delta: 0, 2 or 4
  always_comb begin
    unique case (cls_i.sel)
      SEL_RED:   off_v = '0;
      SEL_GREEN: off_v = {1'b0, cls_i.delta, 1'b0};
      SEL_BLUE:  off_v = {cls_i.delta, 2'b00};
      default:   off_v = '0;
    endcase
  end

  // Hue dividend 120*t + delta with t wrapped to a positive turn
  always_comb begin
    tsum_v = $signed({2'b00, off_v}) + TSUM_W'(cls_i.diff);
    if (tsum_v < 0) begin
      tsum_v = tsum_v + $signed(TSUM_W'(cls_i.delta) * TSUM_W'(6));
    end
    tpos_v = tsum_v[TPOS_W-1:0];

    hue_div_v = (cls_i.delta == '0) ? DIV_W'(1) : {cls_i.delta, 1'b0};
    sat_div_v = (cls_i.mx == '0)    ? DIV_W'(1) : {cls_i.mx, 1'b0};

    stg_nxt.hue.rem = REM_W'(tpos_v) * HUE_SCALE + REM_W'(cls_i.delta);
    stg_nxt.hue.dsh = {hue_div_v, {(QUO_W-1){1'b0}}};
    stg_nxt.hue.quo = '0;

    stg_nxt.sat.rem = REM_W'(cls_i.delta) * SAT_SCALE + REM_W'(cls_i.mx);
    stg_nxt.sat.dsh = {sat_div_v, {(QUO_W-1){1'b0}}};
    stg_nxt.sat.quo = '0;

    bri_prod_v  = PROD_W'(cls_i.mx) * BRI_MUL + BRI_ADD;
    stg_nxt.bri = bri_prod_v[BRI_SHIFT +: PCT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

// ===== design/rhc_div_stage.sv =====
// One stage of the restoring divider: resolves DIV_BITS_PER_STAGE quotient bits per lane.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_stage import rhc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     vld_i,
  input  div_stg_t stg_i,
  output logic     vld_o,
  output div_stg_t stg_o
);

  logic     vld_r;
  div_stg_t stg_r;
  div_stg_t stg_nxt;

  // One restoring step: subtract aligned divisor if it fits, shift it down
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t n;
    n = l;
    if (l.rem >= REM_W'(l.dsh)) begin
      n.rem = l.rem - REM_W'(l.dsh);
      n.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    n.dsh = l.dsh >> 1;
    return n;
  endfunction

  // Run both lanes through this stage's steps
  always_comb begin
    stg_nxt = stg_i;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      stg_nxt.hue = div_step(stg_nxt.hue);
      stg_nxt.sat = div_step(stg_nxt.sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule
